// ===== sv/pdaw_pkg.sv =====
`default_nettype none

package pdaw_pkg;

  localparam int unsigned DW = 32;

  // error deadband edges, Q16.16 (high >= 0, low <= 0)
  localparam logic signed [DW-1:0] DEADBAND_HIGH = 32'sd0;
  localparam logic signed [DW-1:0] DEADBAND_LOW  = 32'sd0;

  localparam logic signed [DW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] SAT_MIN = 32'sh8000_0000;

  localparam logic signed [DW-1:0] RST_OUT_UPPER = 32'sh0001_0000;
  localparam logic signed [DW-1:0] RST_OUT_LOWER = 32'shFFFF_0000;

  typedef enum logic [1:0] {
    MODE_MANUAL  = 2'd0,
    MODE_AUTO    = 2'd1,
    MODE_CLAMP   = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INT_GAIN     = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_OUT_BIAS     = 3'd3,
    REG_OUT_UPPER    = 3'd4,
    REG_OUT_LOWER    = 3'd5,
    REG_WINDUP_UPPER = 3'd6,
    REG_WINDUP_LOWER = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [DW-1:0] prop_gain;
    logic signed [DW-1:0] integral_gain;
    logic signed [DW-1:0] derivative_gain;
    logic signed [DW-1:0] output_bias;
    logic signed [DW-1:0] output_upper;
    logic signed [DW-1:0] output_lower;
    logic signed [DW-1:0] windup_upper;
    logic signed [DW-1:0] windup_lower;
  } cfg_t;

  // raw products handed from the front stage to the back stage
  typedef struct packed {
    mode_t                mode;
    logic signed [DW-1:0] manual_drive;
    logic signed [63:0]   p_prod;
    logic signed [63:0]   d_prod;
    logic signed [64:0]   i_prod;
  } prod_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic signed [DW-1:0] prop_term;
    logic signed [DW-1:0] integral_term;
    logic signed [DW-1:0] deriv_term;
  } res_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [65:0] v);
    logic signed [DW-1:0] r;
    if (v > 66'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < 66'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // divide by 2^sh, round to nearest, ties away from zero
  function automatic logic signed [65:0] round_shr(input logic signed [65:0] v,
                                                   input int unsigned sh);
    logic signed [65:0] half;
    logic signed [65:0] sum;
    half = 66'sd1 <<< (sh - 1);
    sum  = v + half;
    if (v[65]) begin
      sum = sum - 66'sd1;
    end
    return sum >>> sh;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pdaw_front.sv =====
`default_nettype none

// error, deadband, measurement change and the three gain products
module pdaw_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire logic signed [pdaw_pkg::DW-1:0] measurement,
  input  wire logic signed [pdaw_pkg::DW-1:0] target,
  input  wire logic signed [pdaw_pkg::DW-1:0] manual_drive,
  input  wire pdaw_pkg::mode_t                mode,
  input  wire pdaw_pkg::cfg_t                 cfg,
  output pdaw_pkg::prod_t                     prod
);

  logic signed [pdaw_pkg::DW-1:0] prev_meas_r;
  logic signed [pdaw_pkg::DW-1:0] prev_err_r;
  logic signed [pdaw_pkg::DW-1:0] raw_err;
  logic signed [pdaw_pkg::DW-1:0] err;
  logic signed [pdaw_pkg::DW-1:0] dmeas;
  logic signed [pdaw_pkg::DW:0]   err_sum;

  always_comb begin
    raw_err = pdaw_pkg::sat32(66'(target) - 66'(measurement));
    // inside the band -> 0, outside -> shifted by the nearer edge (cannot overflow)
    if (raw_err <= pdaw_pkg::DEADBAND_HIGH && raw_err >= pdaw_pkg::DEADBAND_LOW) begin
      err = '0;
    end else if (raw_err > 32'sd0) begin
      err = raw_err - pdaw_pkg::DEADBAND_HIGH;
    end else begin
      err = raw_err - pdaw_pkg::DEADBAND_LOW;
    end
    dmeas   = pdaw_pkg::sat32(66'(measurement) - 66'(prev_meas_r));
    err_sum = 33'(err) + 33'(prev_err_r);
  end

  always_comb begin
    prod.mode         = mode;
    prod.manual_drive = manual_drive;
    prod.p_prod       = 64'(cfg.prop_gain) * 64'(err);
    prod.d_prod       = 64'(cfg.derivative_gain) * 64'(dmeas);
    prod.i_prod       = 65'(cfg.integral_gain) * 65'(err_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_meas_r <= '0;
      prev_err_r  <= '0;
    end else if (adv) begin
      prev_meas_r <= measurement;
      prev_err_r  <= err;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pdaw_back.sv =====
`default_nettype none

// rounding, headroom, bounded integral and drive selection
module pdaw_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire pdaw_pkg::prod_t prod,
  input  wire pdaw_pkg::cfg_t  cfg,
  output pdaw_pkg::res_t       res
);

  logic signed [pdaw_pkg::DW-1:0] acc_r;
  logic signed [pdaw_pkg::DW-1:0] p;
  logic signed [pdaw_pkg::DW-1:0] d;
  logic signed [pdaw_pkg::DW-1:0] itg;
  logic signed [pdaw_pkg::DW-1:0] total;
  logic signed [pdaw_pkg::DW-1:0] auto_drive;
  logic signed [65:0]             d_rnd;
  logic signed [65:0]             incr;
  logic signed [35:0]             base;
  logic signed [35:0]             hp;
  logic signed [35:0]             hn;
  logic signed [35:0]             it;

  always_comb begin
    p     = pdaw_pkg::sat32(pdaw_pkg::round_shr(66'(prod.p_prod), 16));
    d_rnd = pdaw_pkg::round_shr(66'(prod.d_prod), 16);
    d     = pdaw_pkg::sat32(-d_rnd);
    incr  = pdaw_pkg::round_shr(66'(prod.i_prod), 17);

    base = 36'(cfg.output_bias) + 36'(p) + 36'(d);
    hp   = 36'(cfg.output_upper) - base;
    hn   = 36'(cfg.output_lower) - base;
    if (hp < 36'sd0) begin
      hp = '0;
    end
    if (hn > 36'sd0) begin
      hn = '0;
    end

    if (cfg.integral_gain == '0) begin
      it = '0;
    end else begin
      it = 36'(pdaw_pkg::sat32(66'(acc_r) + incr));
    end
    // later limits win when they cross
    if (it > 36'(cfg.windup_upper)) begin
      it = 36'(cfg.windup_upper);
    end
    if (it < 36'(cfg.windup_lower)) begin
      it = 36'(cfg.windup_lower);
    end
    if (it > hp) begin
      it = hp;
    end
    if (it < hn) begin
      it = hn;
    end
    itg = it[pdaw_pkg::DW-1:0];

    total = pdaw_pkg::sat32(66'(base) + 66'(itg));
    priority if (hn == '0) begin
      auto_drive = cfg.output_lower;
    end else if (hp == '0) begin
      auto_drive = cfg.output_upper;
    end else begin
      auto_drive = total;
    end

    unique case (prod.mode)
      pdaw_pkg::MODE_MANUAL: begin
        priority if (prod.manual_drive < cfg.output_lower) begin
          res.drive = cfg.output_lower;
        end else if (prod.manual_drive > cfg.output_upper) begin
          res.drive = cfg.output_upper;
        end else begin
          res.drive = prod.manual_drive;
        end
      end
      pdaw_pkg::MODE_CLAMP: res.drive = '0;
      default:              res.drive = auto_drive;
    endcase
    res.prop_term     = p;
    res.integral_term = itg;
    res.deriv_term    = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv) begin
      acc_r <= (prod.mode == pdaw_pkg::MODE_RESTART) ? '0 : itg;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pid_deadband_antiwindup.sv =====
// Pipeline: an accepted request lands in the input register, then the product
//   register, then the result register, before out_valid rises.
// Throughput: one request per cycle while out_ready holds; the integral feedback
//   closes within the result stage, so consecutive samples never wait on each other.
// Restart requests give no result. Synchronous active-low reset clears the
//   pipeline valids, history and integral, and loads the register defaults.
`default_nettype none

module pid_deadband_antiwindup (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [pdaw_pkg::DW-1:0] in_measurement,
  input  wire logic signed [pdaw_pkg::DW-1:0] in_target,
  input  wire logic signed [pdaw_pkg::DW-1:0] in_manual_drive,
  input  wire logic [1:0]                     in_mode,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [pdaw_pkg::DW-1:0]      out_drive,
  output logic signed [pdaw_pkg::DW-1:0]      out_prop_term,
  output logic signed [pdaw_pkg::DW-1:0]      out_integral_term,
  output logic signed [pdaw_pkg::DW-1:0]      out_deriv_term,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [pdaw_pkg::DW-1:0]        cfg_data
);

  pdaw_pkg::cfg_t  cfg_r;
  pdaw_pkg::prod_t prod;
  pdaw_pkg::prod_t prod_r;
  pdaw_pkg::res_t  res;
  pdaw_pkg::res_t  res_r;
  pdaw_pkg::mode_t mode_r;

  logic                           in_v_r;
  logic                           st_v_r;
  logic                           out_v_r;
  logic signed [pdaw_pkg::DW-1:0] meas_r;
  logic signed [pdaw_pkg::DW-1:0] tgt_r;
  logic signed [pdaw_pkg::DW-1:0] man_r;
  logic                           rdy1;
  logic                           rdy2;
  logic                           adv0;
  logic                           adv1;
  logic                           st_has_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= '0;
      cfg_r.integral_gain   <= '0;
      cfg_r.derivative_gain <= '0;
      cfg_r.output_bias     <= '0;
      cfg_r.output_upper    <= pdaw_pkg::RST_OUT_UPPER;
      cfg_r.output_lower    <= pdaw_pkg::RST_OUT_LOWER;
      cfg_r.windup_upper    <= pdaw_pkg::RST_OUT_UPPER;
      cfg_r.windup_lower    <= pdaw_pkg::RST_OUT_LOWER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pdaw_pkg::reg_idx_t'(cfg_index))
        pdaw_pkg::REG_PROP_GAIN:    cfg_r.prop_gain       <= cfg_data;
        pdaw_pkg::REG_INT_GAIN:     cfg_r.integral_gain   <= cfg_data;
        pdaw_pkg::REG_DERIV_GAIN:   cfg_r.derivative_gain <= cfg_data;
        pdaw_pkg::REG_OUT_BIAS:     cfg_r.output_bias     <= cfg_data;
        pdaw_pkg::REG_OUT_UPPER:    cfg_r.output_upper    <= cfg_data;
        pdaw_pkg::REG_OUT_LOWER:    cfg_r.output_lower    <= cfg_data;
        pdaw_pkg::REG_WINDUP_UPPER: cfg_r.windup_upper    <= cfg_data;
        pdaw_pkg::REG_WINDUP_LOWER: cfg_r.windup_lower    <= cfg_data;
      endcase
    end
  end

  // each stage moves when the one after it is empty or moving
  assign rdy2       = !out_v_r || out_ready;
  assign rdy1       = !st_v_r || rdy2;
  assign in_ready   = !in_v_r || rdy1;
  assign adv0       = in_v_r && rdy1;
  assign adv1       = st_v_r && rdy2;
  assign st_has_res = prod_r.mode != pdaw_pkg::MODE_RESTART;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      st_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (rdy1) begin
        st_v_r <= in_v_r;
      end
      if (rdy2) begin
        out_v_r <= st_v_r && st_has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r <= in_measurement;
      tgt_r  <= in_target;
      man_r  <= in_manual_drive;
      mode_r <= pdaw_pkg::mode_t'(in_mode);
    end
    if (adv0) begin
      prod_r <= prod;
    end
    if (adv1 && st_has_res) begin
      res_r <= res;
    end
  end

  pdaw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv0),
    .measurement  (meas_r),
    .target       (tgt_r),
    .manual_drive (man_r),
    .mode         (mode_r),
    .cfg          (cfg_r),
    .prod         (prod)
  );

  pdaw_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv1),
    .prod  (prod_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid         = out_v_r;
  assign out_drive         = res_r.drive;
  assign out_prop_term     = res_r.prop_term;
  assign out_integral_term = res_r.integral_term;
  assign out_deriv_term    = res_r.deriv_term;

endmodule

`default_nettype wire

// ===== sv/pdaw_checker.sv =====
`default_nettype none

module pdaw_checker (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic [1:0]              in_mode,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [pdaw_pkg::DW-1:0] out_drive
);

  // requests accepted that still owe a result
  logic [2:0] pend_r;
  logic       in_res;
  logic       out_fire;

  assign in_res   = in_valid && in_ready && (in_mode != pdaw_pkg::MODE_RESTART);
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_res) - 3'(out_fire);
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without a pending request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more requests in flight than pipeline stages");

  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive))
    else $error("stalled result changed");

endmodule

bind pid_deadband_antiwindup pdaw_checker u_pdaw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_mode   (in_mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_drive (out_drive)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import pdaw_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [DW-1:0] q16_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  localparam wide_t WIDE_MAX = wide_t'(SAT_MAX);
  localparam wide_t WIDE_MIN = wide_t'(SAT_MIN);
  localparam q16_t  ONE_Q    = 32'sh0001_0000;
  localparam q16_t  HALF_Q   = 32'sh0000_8000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 12;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  q16_t      in_measurement = '0;
  q16_t      in_target = '0;
  q16_t      in_manual_drive = '0;
  mode_t     in_mode = MODE_AUTO;
  logic      out_valid;
  logic      out_ready = 1'b0;
  q16_t      out_drive;
  q16_t      out_prop_term;
  q16_t      out_integral_term;
  q16_t      out_deriv_term;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  reg_idx_t  cfg_index = REG_PROP_GAIN;
  logic [DW-1:0] cfg_data = '0;

  // controller copy: register values and loop history
  cfg_t ctl;
  q16_t last_meas = '0;
  q16_t last_err = '0;
  q16_t integ_acc = '0;
  res_t pid_outputs[$];

  int          fail_count = 0;
  bit          steady = 1'b0;
  int unsigned burst_left = 0;
  q16_t        sp_anchor = '0;
  q16_t        meas_anchor = '0;

  rx_style_t   rx_style = RX_RANDOM;
  logic [15:0] rx_pat = 16'hB6D9;
  logic [3:0]  rx_pos = '0;
  int unsigned hold_req = 0;
  int unsigned holds_taken = 0;
  int unsigned hold_left = 0;

  pid_deadband_antiwindup dut (.*);

  always #2 clk = ~clk;

  function automatic q16_t clip32(input wide_t v);
    if (v > WIDE_MAX) return SAT_MAX;
    if (v < WIDE_MIN) return SAT_MIN;
    return v[DW-1:0];
  endfunction

  // exact a*b (negated if flip), scaled by 2^-sh, nearest with ties away from zero
  function automatic wide_t mul_rnd(input wide_t a, input wide_t b, input bit flip,
                                    input int unsigned sh);
    wide_t prod;
    wide_t mag;
    bit    neg;
    prod = a * b;
    neg  = flip ^ prod[127];
    mag  = prod[127] ? -prod : prod;
    mag  = (mag + (wide_t'(1) <<< (sh - 1))) >>> sh;
    return neg ? -mag : mag;
  endfunction

  function automatic q16_t band_err(input q16_t e);
    if (e <= DEADBAND_HIGH && e >= DEADBAND_LOW) return '0;
    if (e > 0) return clip32(wide_t'(e) - wide_t'(DEADBAND_HIGH));
    return clip32(wide_t'(e) - wide_t'(DEADBAND_LOW));
  endfunction

  function automatic bit pid_step(input q16_t meas, input q16_t tgt, input q16_t man,
                                  input mode_t md, output res_t r);
    q16_t  kp, ki, kd, bias, ohi, olo, whi, wlo;
    q16_t  err, p, d, itg, drv;
    wide_t base, hp, hn, acc;
    kp   = ctl.prop_gain;
    ki   = ctl.integral_gain;
    kd   = ctl.derivative_gain;
    bias = ctl.output_bias;
    ohi  = ctl.output_upper;
    olo  = ctl.output_lower;
    whi  = ctl.windup_upper;
    wlo  = ctl.windup_lower;
    r    = '0;
    err  = band_err(clip32(wide_t'(tgt) - wide_t'(meas)));
    if (md == MODE_RESTART) begin
      last_meas = meas;
      last_err  = err;
      integ_acc = '0;
      return 1'b0;
    end
    p = clip32(mul_rnd(kp, err, 1'b0, 16));
    d = clip32(mul_rnd(kd, clip32(wide_t'(meas) - wide_t'(last_meas)), 1'b1, 16));
    base = wide_t'(bias) + wide_t'(p) + wide_t'(d);
    hp = wide_t'(ohi) - base;
    hn = wide_t'(olo) - base;
    if (hp < 0) hp = '0;
    if (hn > 0) hn = '0;
    if (ki == 0) begin
      acc = '0;
    end else begin
      acc = clip32(wide_t'(integ_acc) +
                   mul_rnd(ki, wide_t'(err) + wide_t'(last_err), 1'b0, 17));
    end
    // later limits win when they cross
    if (acc > whi) acc = whi;
    if (acc < wlo) acc = wlo;
    if (acc > hp) acc = hp;
    if (acc < hn) acc = hn;
    itg = clip32(acc);
    drv = clip32(base + wide_t'(itg));
    if (hp == 0) drv = ohi;
    if (hn == 0) drv = olo;
    case (md)
      MODE_CLAMP: drv = '0;
      MODE_MANUAL: begin
        drv = man;
        if (man > ohi) drv = ohi;
        if (man < olo) drv = olo;
      end
      default: ;
    endcase
    last_meas = meas;
    last_err  = err;
    integ_acc = itg;
    r.drive         = drv;
    r.prop_term     = p;
    r.integral_term = itg;
    r.deriv_term    = d;
    return 1'b1;
  endfunction

  function automatic q16_t pick_val(input q16_t anchor);
    q16_t v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: v = $urandom;
      4: v = SAT_MAX;
      5: v = SAT_MIN;
      6: v = '0;
      7: v = -32'sd1;
      8, 9, 10, 11, 12, 13: begin
        v = clip32(wide_t'(anchor) +
                   wide_t'(int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000));
      end
      default: v = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
    return v;
  endfunction

  function automatic q16_t pick_gain();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.prop_gain       = pick_gain();
    c.integral_gain   = ($urandom_range(0, 3) == 0) ? '0 : pick_gain();
    c.derivative_gain = pick_gain();
    c.output_bias     = pick_val('0);
    if ($urandom_range(0, 4) == 0) begin
      c.output_upper = $urandom;
      c.output_lower = $urandom;
      c.windup_upper = $urandom;
      c.windup_lower = $urandom;
    end else begin
      c.output_upper = $urandom_range(32'h0000_0100, 32'h0008_0000);
      c.output_lower = -int'($urandom_range(32'h0000_0100, 32'h0008_0000));
      c.windup_upper = $urandom_range(0, 32'h0010_0000);
      c.windup_lower = -int'($urandom_range(0, 32'h0010_0000));
    end
    return c;
  endfunction

  task automatic check_field(input string field, input q16_t want, input q16_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // writes all eight registers; only called with the block idle
  task automatic apply_settings(input cfg_t c);
    reg_idx_t      ri;
    logic [DW-1:0] val;
    ri = ri.first();
    repeat (ri.num()) begin
      case (ri)
        REG_PROP_GAIN:    val = c.prop_gain;
        REG_INT_GAIN:     val = c.integral_gain;
        REG_DERIV_GAIN:   val = c.derivative_gain;
        REG_OUT_BIAS:     val = c.output_bias;
        REG_OUT_UPPER:    val = c.output_upper;
        REG_OUT_LOWER:    val = c.output_lower;
        REG_WINDUP_UPPER: val = c.windup_upper;
        default:          val = c.windup_lower;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= ri;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      ri = ri.next();
    end
    cfg_valid <= 1'b0;
    ctl = c;
  endtask

  task automatic send_sample(input q16_t meas, input q16_t tgt, input q16_t man,
                             input mode_t md);
    res_t        r;
    int unsigned gap;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid        <= 1'b1;
    in_measurement  <= meas;
    in_target       <= tgt;
    in_manual_drive <= man;
    in_mode         <= md;
    do @(posedge clk); while (!in_ready);
    if (pid_step(meas, tgt, man, md, r)) pid_outputs.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_random_sample();
    q16_t        meas;
    int unsigned r;
    mode_t       md;
    if ($urandom_range(0, 9) == 0) sp_anchor = pick_val(sp_anchor);
    meas = pick_val(meas_anchor);
    r = $urandom_range(0, 19);
    if (r < 11) md = MODE_AUTO;
    else if (r < 15) md = MODE_MANUAL;
    else if (r < 18) md = MODE_CLAMP;
    else md = MODE_RESTART;
    send_sample(meas, sp_anchor, pick_val('0), md);
    meas_anchor = meas;
  endtask

  // restart requests give no result, so allow the pipeline to settle as well
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pid_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pid_outputs.size() != 0) begin
      $error("%0d expected results never arrived", pid_outputs.size());
      fail_count++;
      pid_outputs.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_sample('0, '0, '0, MODE_AUTO);
    send_sample('0, ONE_Q, SAT_MAX, MODE_MANUAL);
    send_sample('0, '0, SAT_MIN, MODE_MANUAL);
    send_sample(SAT_MAX, SAT_MIN, '0, MODE_CLAMP);
    send_sample(SAT_MIN, SAT_MAX, '0, MODE_RESTART);
    send_sample(SAT_MIN, '0, '0, MODE_AUTO);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    cfg_t c;
    c = '{prop_gain: 32'sh0002_0000, integral_gain: HALF_Q, derivative_gain: ONE_Q,
          output_bias: '0, output_upper: SAT_MAX, output_lower: SAT_MIN,
          windup_upper: SAT_MAX, windup_lower: SAT_MIN};
    apply_settings(c);
    send_sample(SAT_MIN, SAT_MAX, '0, MODE_AUTO);
    send_sample(SAT_MAX, SAT_MIN, '0, MODE_AUTO);
    send_sample(SAT_MAX, SAT_MAX, SAT_MAX, MODE_MANUAL);
    send_sample(HALF_Q, ONE_Q, SAT_MIN, MODE_MANUAL);
    send_sample(32'sd1, -32'sd1, -32'sd1, MODE_RESTART);
    send_sample(-32'sd1, 32'sd1, 32'sd1, MODE_AUTO);
    wait_drained();
  endtask

  task automatic test_headroom_limits();
    cfg_t c;
    // bias alone exceeds the upper limit: no positive headroom
    c = '{prop_gain: ONE_Q, integral_gain: ONE_Q, derivative_gain: '0,
          output_bias: SAT_MAX, output_upper: ONE_Q, output_lower: -ONE_Q,
          windup_upper: SAT_MAX, windup_lower: SAT_MIN};
    apply_settings(c);
    send_sample('0, 32'sh0000_4000, '0, MODE_AUTO);
    send_sample('0, 32'sh0000_4000, '0, MODE_AUTO);
    wait_drained();
    // crossed output and windup limits
    c = '{prop_gain: ONE_Q, integral_gain: ONE_Q, derivative_gain: '0,
          output_bias: '0, output_upper: -ONE_Q, output_lower: ONE_Q,
          windup_upper: -HALF_Q, windup_lower: HALF_Q};
    apply_settings(c);
    send_sample('0, 32'sh0002_0000, '0, MODE_AUTO);
    send_sample('0, -32'sh0002_0000, '0, MODE_AUTO);
    send_sample('0, '0, SAT_MAX, MODE_MANUAL);
    wait_drained();
  endtask

  task automatic test_rounding_ties();
    cfg_t c;
    c = '{prop_gain: HALF_Q, integral_gain: 32'sd1, derivative_gain: -HALF_Q,
          output_bias: '0, output_upper: SAT_MAX, output_lower: SAT_MIN,
          windup_upper: SAT_MAX, windup_lower: SAT_MIN};
    apply_settings(c);
    send_sample('0, '0, '0, MODE_RESTART);
    send_sample(32'sd1, '0, '0, MODE_AUTO);
    send_sample(-32'sd1, '0, '0, MODE_AUTO);
    wait_drained();
  endtask

  task automatic test_backpressure();
    rx_style <= RX_ALWAYS;
    hold_req <= hold_req + 1;
    steady = 1'b1;
    repeat (40) send_random_sample();
    // input pauses until everything sent so far is back
    wait_drained();
    steady = 1'b0;
    repeat (10) send_random_sample();
    wait_drained();
  endtask

  task automatic test_random_phases();
    cfg_t c;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: c = '{prop_gain: SAT_MAX, integral_gain: SAT_MAX, derivative_gain: SAT_MAX,
                 output_bias: SAT_MAX, output_upper: SAT_MAX, output_lower: SAT_MIN,
                 windup_upper: SAT_MAX, windup_lower: SAT_MIN};
        1: c = '{prop_gain: SAT_MIN, integral_gain: SAT_MIN, derivative_gain: SAT_MIN,
                 output_bias: SAT_MIN, output_upper: SAT_MIN, output_lower: SAT_MAX,
                 windup_upper: SAT_MIN, windup_lower: SAT_MAX};
        2: c = '0;
        default: c = random_settings();
      endcase
      steady = (p == 3) || ($urandom_range(0, 3) == 0);
      rx_style <= (p == 3) ? RX_ALWAYS : rx_style_t'($urandom_range(0, 2));
      rx_pat <= 16'($urandom) | 16'h0101;
      apply_settings(c);
      repeat (110) send_random_sample();
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_taken != hold_req) begin
      // long output stall so the pipeline backs up into the input
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      holds_taken <= holds_taken + 1;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= rx_pat[rx_pos];
      endcase
      rx_pos <= rx_pos + 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pid_outputs.size() == 0) begin
        $error("result with no request pending: drive %0d", out_drive);
        fail_count++;
      end else begin
        want = pid_outputs.pop_front();
        check_field("drive", want.drive, out_drive);
        check_field("prop_term", want.prop_term, out_prop_term);
        check_field("integral_term", want.integral_term, out_integral_term);
        check_field("deriv_term", want.deriv_term, out_deriv_term);
      end
    end
  end

  initial begin
    ctl = '{prop_gain: '0, integral_gain: '0, derivative_gain: '0, output_bias: '0,
            output_upper: RST_OUT_UPPER, output_lower: RST_OUT_LOWER,
            windup_upper: RST_OUT_UPPER, windup_lower: RST_OUT_LOWER};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_headroom_limits();
    test_rounding_ties();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
